[design/ptts_pkg.sv]
// ---------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the periodic task timer scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int COUNT_W     = $clog2(SLOTS + 1);
  localparam int TICK_W      = 32;
  localparam int OP_W        = 3;
  localparam int EV_W        = 3;
  localparam int IN_DATA_W   = ((SLOT_W + 2 * TICK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((SLOT_W + EV_W + TICK_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_TASK_COUNT = '0;

  typedef enum logic [OP_W-1:0] {
    OP_STEP     = 3'd0,
    OP_INTERVAL = 3'd1,
    OP_START    = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_AWAKE    = 3'd4,
    OP_SUSPEND  = 3'd5,
    OP_RESUME   = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT      = 3'd0,
    ST_PREPARE   = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_SLEEPING  = 3'd3,
    ST_SUSPENDED = 3'd4
  } task_state_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PREPARE = 3'd1,
    EV_START   = 3'd2,
    EV_AWAKE   = 3'd3,
    EV_RESUME  = 3'd4,
    EV_SLEEP   = 3'd5,
    EV_SUSPEND = 3'd6,
    EV_RUN     = 3'd7
  } event_t;

  typedef struct packed {
    task_state_t         state;
    task_state_t         reported;
    logic [TICK_W-1:0]   next_run;
    logic [TICK_W-1:0]   interval;
  } slot_entry_t;

  localparam slot_entry_t ENTRY_RESET = '{
    state:    ST_INIT,
    reported: ST_INIT,
    next_run: '0,
    interval: '0
  };

  // Outcome of one operation on one slot entry.
  typedef struct packed {
    logic   wr_en;
    event_t ev;
  } engine_res_t;

endpackage

`default_nettype wire

[design/ptts_table.sv]
// ---------------------------------------------------------------------------
// ptts_table
// Slot table: one synchronous memory of slot entries with a registered read
// port, plus one valid bit per entry so that unwritten entries read as reset.
// ---------------------------------------------------------------------------
`default_nettype none

module ptts_table
  import ptts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output slot_entry_t            rd_data,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_addr,
  input  wire slot_entry_t       wr_data
);

  slot_entry_t           mem [SLOTS];
  logic [SLOTS-1:0]      valid_r;
  slot_entry_t           rd_data_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : ENTRY_RESET;

endmodule

`default_nettype wire

[design/ptts_engine.sv]
// ---------------------------------------------------------------------------
// ptts_engine
// Update logic for one slot entry: applies a slot operation or serves the
// slot for a schedule step, and reports the event it causes.
// ---------------------------------------------------------------------------
`default_nettype none

module ptts_engine
  import ptts_pkg::*;
(
  input  wire op_t               op,
  input  wire logic              step_empty,
  input  wire logic [TICK_W-1:0] delay,
  input  wire logic [TICK_W-1:0] now_tick,
  input  wire slot_entry_t       cur,
  output slot_entry_t            upd,
  output engine_res_t            res
);

  logic [TICK_W-1:0] step_add;
  logic [TICK_W-1:0] plan_sum;
  logic              due;

  // One adder serves every rescheduling path. A step adds the interval, or
  // the stored start delay when a prepared slot is reported.
  always_comb begin
    if (op == OP_STEP) begin
      step_add = (cur.state == ST_PREPARE) ? cur.next_run : cur.interval;
    end else begin
      step_add = (delay == '0) ? cur.interval : delay;
    end
  end

  assign plan_sum = now_tick + step_add;
  assign due      = (now_tick >= cur.next_run);

  always_comb begin
    upd       = cur;
    res.ev    = EV_NONE;
    res.wr_en = !((op == OP_NOP) || ((op == OP_STEP) && step_empty));
    case (op)
      OP_STEP: begin
        case (cur.state)
          ST_PREPARE: begin
            if (cur.reported != ST_PREPARE) begin
              res.ev       = EV_PREPARE;
              upd.reported = ST_PREPARE;
              upd.state    = ST_RUNNING;
              upd.next_run = plan_sum;
            end
          end
          ST_RUNNING: begin
            if (cur.reported != ST_RUNNING) begin
              case (cur.reported)
                ST_PREPARE:   res.ev = EV_START;
                ST_SLEEPING:  res.ev = EV_AWAKE;
                ST_SUSPENDED: res.ev = EV_RESUME;
                default:      res.ev = EV_NONE;
              endcase
              upd.reported = ST_RUNNING;
            end else if (due) begin
              upd.next_run = plan_sum;
              res.ev       = EV_RUN;
            end
          end
          ST_SLEEPING: begin
            if (cur.reported != ST_SLEEPING) begin
              res.ev       = EV_SLEEP;
              upd.reported = ST_SLEEPING;
            end else if (due) begin
              // Wakes silently; the next visit reports the awake event.
              upd.next_run = plan_sum;
              upd.state    = ST_RUNNING;
            end
          end
          ST_SUSPENDED: begin
            if (cur.reported != ST_SUSPENDED) begin
              res.ev       = EV_SUSPEND;
              upd.reported = ST_SUSPENDED;
            end
          end
          default: begin
          end
        endcase
      end
      OP_INTERVAL: begin
        upd.interval = delay;
      end
      OP_START: begin
        if (cur.state == ST_INIT) begin
          upd.next_run = delay;
          upd.state    = ST_PREPARE;
        end
      end
      OP_SLEEP: begin
        if (cur.state != ST_SLEEPING) begin
          upd.next_run = plan_sum;
          upd.state    = ST_SLEEPING;
        end
      end
      OP_AWAKE: begin
        if (cur.state == ST_SLEEPING) begin
          upd.next_run = plan_sum;
          upd.state    = ST_RUNNING;
        end
      end
      OP_SUSPEND: begin
        upd.state = ST_SUSPENDED;
      end
      OP_RESUME: begin
        if (cur.state == ST_SUSPENDED) begin
          upd.next_run = plan_sum;
          upd.state    = ST_RUNNING;
        end
      end
      default: begin
      end
    endcase
    // A step with no slots in use reports nothing.
    if ((op == OP_STEP) && step_empty) begin
      res.ev = EV_NONE;
    end
  end

endmodule

`default_nettype wire

[design/periodic_task_timer_scheduler.sv]
// ---------------------------------------------------------------------------
// periodic_task_timer_scheduler
// Table of periodic task timers with slot operations and a round-robin
// schedule step that reports state changes and due runs.
// ---------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      tuser: operation; tdata: task_slot, delay, now_tick
//  out_     master     tdata: served_slot, event_res, next_run_tick
//  cfg_     APB        register 0 at byte 0: task_count
//
//  Accepting an item reads its slot entry from the table; the item then
//  updates the entry, writes it back and loads the result.
//  The result waits in an output register, so the next item is accepted
//  while it is stalled; an item finished behind a stalled result waits.
//  Reset is synchronous; the table's valid bits make every entry read as
//  its reset value at once, so there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_task_timer_scheduler
  import ptts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // task_slot, delay, now_tick, zero pad
  input  wire logic [OP_W-1:0]       in_tuser,  // operation
  // result items
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata, // served_slot, event_res, next_run_tick, pad
  // configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

  fsm_t                state_r;
  logic [COUNT_W-1:0]  task_count_r;
  logic [SLOT_W-1:0]   cur_slot_r;
  logic [SLOT_W-1:0]   cur_slot_nxt;
  op_t                 op_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [TICK_W-1:0]   delay_r;
  logic [TICK_W-1:0]   now_r;
  logic                step_empty_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  op_t                 in_op;
  logic [SLOT_W-1:0]   in_slot;
  logic [TICK_W-1:0]   in_delay;
  logic [TICK_W-1:0]   in_now;
  logic [COUNT_W-1:0]  used;
  logic [SLOT_W-1:0]   step_slot;
  logic [COUNT_W-1:0]  step_slot_inc;
  logic [SLOT_W-1:0]   rd_addr;
  logic                accept;
  logic                fire;
  logic                cfg_wr;

  slot_entry_t         rd_entry;
  slot_entry_t         upd_entry;
  engine_res_t         eng_res;
  logic [TICK_W-1:0]   res_tick;

  assign in_op    = op_t'(in_tuser);
  assign in_slot  = in_tdata[SLOT_W-1:0];
  assign in_delay = in_tdata[SLOT_W +: TICK_W];
  assign in_now   = in_tdata[SLOT_W + TICK_W +: TICK_W];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // Slots in use, clamped to the table size.
  assign used = (task_count_r > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : task_count_r;

  always_comb begin
    step_slot     = ({1'b0, cur_slot_r} >= used) ? '0 : cur_slot_r;
    step_slot_inc = {1'b0, step_slot} + COUNT_W'(1);
    cur_slot_nxt  = cur_slot_r;
    if (accept && (in_op == OP_STEP) && (used != '0)) begin
      cur_slot_nxt = (step_slot_inc < used) ? step_slot_inc[SLOT_W-1:0] : '0;
    end
  end

  assign rd_addr = (in_op == OP_STEP) ? step_slot : in_slot;

  ptts_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_entry),
    .wr_en   (fire && eng_res.wr_en),
    .wr_addr (slot_r),
    .wr_data (upd_entry)
  );

  ptts_engine u_engine (
    .op         (op_r),
    .step_empty (step_empty_r),
    .delay      (delay_r),
    .now_tick   (now_r),
    .cur        (rd_entry),
    .upd        (upd_entry),
    .res        (eng_res)
  );

  // Ignored items report no tick.
  assign res_tick = eng_res.wr_en ? upd_entry.next_run : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_slot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_slot_r <= cur_slot_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r      <= S_EXEC;
            op_r         <= in_op;
            slot_r       <= rd_addr;
            delay_r      <= in_delay;
            now_r        <= in_now;
            step_empty_r <= (in_op == OP_STEP) && (used == '0);
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_r     <= S_IDLE;
            out_data_r  <= OUT_DATA_W'({res_tick, eng_res.ev,
                                        step_empty_r ? {SLOT_W{1'b0}} : slot_r});
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= '0;
    end else if (cfg_wr && (cfg_paddr == REG_TASK_COUNT)) begin
      task_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_TASK_COUNT) begin
      cfg_prdata = 32'(task_count_r);
    end
  end

endmodule

`default_nettype wire

[design/ptts_checker.sv]
// ---------------------------------------------------------------------------
// ptts_checker
// Port-level checks for the periodic task timer scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

module ptts_checker
  import ptts_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in work");

  // A finished item cannot leave while the output register is blocked.
  a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tvalid && !out_tready |=> !in_tready)
    else $error("item completed over a stalled result");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind periodic_task_timer_scheduler ptts_checker u_ptts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[sim/periodic_task_timer_scheduler_test.sv]
// ---------------------------------------------------------------------------
// periodic_task_timer_scheduler_test
// Self-checking bench for the task timer table. A directed table walks the
// slot life cycle (prepare, start, run, sleep, wake, suspend, resume), then
// random phases at several task counts and idling mixes run against a
// behavioral copy of the slot table, including one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_timer_scheduler_test;
  import ptts_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    event_t            ev;
    logic [TICK_W-1:0] nrt;
  } sched_res_t;

  typedef struct packed {
    logic              is_cfg;   // register write row; d holds the task count
    logic              typed;    // expected result given in the row
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] d;
    logic [TICK_W-1:0] now;
    sched_res_t        res;
  } stim_row_t;

  localparam int N_DIR = 28;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 56;

  localparam stim_row_t DIR_TAB [N_DIR] = '{
    '{1'b0, 1'b1, OP_STEP,     4'd0,  32'd0,          32'd0,          '{4'd0, EV_NONE, 32'd0}},
    '{1'b0, 1'b1, OP_NOP,      4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  '{4'd15, EV_NONE, 32'd0}},
    '{1'b0, 1'b1, OP_INTERVAL, 4'd0,  32'd5,          32'd0,          '{4'd0, EV_NONE, 32'd0}},
    '{1'b0, 1'b1, OP_INTERVAL, 4'd1,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  '{4'd1, EV_NONE, 32'd0}},
    '{1'b0, 1'b1, OP_START,    4'd0,  32'd3,          32'd100,        '{4'd0, EV_NONE, 32'd3}},
    '{1'b0, 1'b1, OP_START,    4'd1,  32'd0,          32'd0,          '{4'd1, EV_NONE, 32'd0}},
    '{1'b0, 1'b1, OP_SUSPEND,  4'd2,  32'd0,          32'd0,          '{4'd2, EV_NONE, 32'd0}},
    '{1'b0, 1'b0, OP_RESUME,   4'd2,  32'd0,          32'd50,         '0},
    '{1'b1, 1'b0, OP_STEP,     4'd0,  32'd2,          32'd0,          '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd100,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd100,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd100,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd100,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd103,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd100,        '0},
    '{1'b0, 1'b0, OP_SLEEP,    4'd0,  32'd0,          32'd200,        '0},
    '{1'b0, 1'b0, OP_SUSPEND,  4'd1,  32'd0,          32'd200,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd200,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd200,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd205,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd205,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd205,        '0},
    '{1'b0, 1'b0, OP_RESUME,   4'd1,  32'd7,          32'hFFFF_FFFE,  '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'hFFFF_FFFE,  '0},
    '{1'b1, 1'b0, OP_STEP,     4'd0,  32'd20,         32'd0,          '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd300,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd300,        '0},
    '{1'b0, 1'b0, OP_STEP,     4'd0,  32'd0,          32'd300,        '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // task_slot, delay, now_tick, zero pad
  logic [OP_W-1:0]       in_tuser;   // operation
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // served_slot, event_res, next_run_tick, pad
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  periodic_task_timer_scheduler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Behavioral copy of the slot table.
  task_state_t       tbl_state    [SLOTS];
  task_state_t       tbl_reported [SLOTS];
  logic [TICK_W-1:0] tbl_next_run [SLOTS];
  logic [TICK_W-1:0] tbl_interval [SLOTS];
  int                rr_slot;
  int                slots_in_use;

  sched_res_t pending_results [$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  function automatic logic [TICK_W-1:0] plan_tick(int s, logic [TICK_W-1:0] now,
                                                  logic [TICK_W-1:0] d);
    return now + ((d == '0) ? tbl_interval[s] : d);
  endfunction

  function automatic sched_res_t slot_table_result(op_t op, logic [SLOT_W-1:0] slot,
                                                   logic [TICK_W-1:0] d,
                                                   logic [TICK_W-1:0] now);
    sched_res_t res;
    int n;
    int s;
    res = '0;
    res.ev = EV_NONE;
    n = (slots_in_use > SLOTS) ? SLOTS : slots_in_use;
    if (op == OP_STEP) begin
      if (n == 0) return res;
      if (rr_slot >= n) rr_slot = 0;
      s = rr_slot;
      case (tbl_state[s])
        ST_PREPARE: begin
          if (tbl_reported[s] != ST_PREPARE) begin
            res.ev = EV_PREPARE;
            tbl_reported[s] = ST_PREPARE;
            tbl_state[s] = ST_RUNNING;
            tbl_next_run[s] = tbl_next_run[s] + now;
          end
        end
        ST_RUNNING: begin
          if (tbl_reported[s] != ST_RUNNING) begin
            case (tbl_reported[s])
              ST_PREPARE:   res.ev = EV_START;
              ST_SLEEPING:  res.ev = EV_AWAKE;
              ST_SUSPENDED: res.ev = EV_RESUME;
              default:      res.ev = EV_NONE;  // first report is silent
            endcase
            tbl_reported[s] = ST_RUNNING;
          end else if (now >= tbl_next_run[s]) begin
            tbl_next_run[s] = plan_tick(s, now, '0);
            res.ev = EV_RUN;
          end
        end
        ST_SLEEPING: begin
          if (tbl_reported[s] != ST_SLEEPING) begin
            res.ev = EV_SLEEP;
            tbl_reported[s] = ST_SLEEPING;
          end else if (now >= tbl_next_run[s]) begin
            // Wakes silently; the awake event comes on the next visit.
            tbl_next_run[s] = plan_tick(s, now, '0);
            tbl_state[s] = ST_RUNNING;
          end
        end
        ST_SUSPENDED: begin
          if (tbl_reported[s] != ST_SUSPENDED) begin
            res.ev = EV_SUSPEND;
            tbl_reported[s] = ST_SUSPENDED;
          end
        end
        default: ;
      endcase
      rr_slot = (s + 1 < n) ? s + 1 : 0;
      res.slot = s[SLOT_W-1:0];
      res.nrt = tbl_next_run[s];
      return res;
    end
    res.slot = slot;
    if (op == OP_NOP) return res;
    s = slot;
    case (op)
      OP_INTERVAL: tbl_interval[s] = d;
      OP_START: begin
        if (tbl_state[s] == ST_INIT) begin
          tbl_next_run[s] = d;
          tbl_state[s] = ST_PREPARE;
        end
      end
      OP_SLEEP: begin
        if (tbl_state[s] != ST_SLEEPING) begin
          tbl_next_run[s] = plan_tick(s, now, d);
          tbl_state[s] = ST_SLEEPING;
        end
      end
      OP_AWAKE: begin
        if (tbl_state[s] == ST_SLEEPING) begin
          tbl_next_run[s] = plan_tick(s, now, d);
          tbl_state[s] = ST_RUNNING;
        end
      end
      OP_SUSPEND: tbl_state[s] = ST_SUSPENDED;
      default: begin
        if (tbl_state[s] == ST_SUSPENDED) begin
          tbl_next_run[s] = plan_tick(s, now, d);
          tbl_state[s] = ST_RUNNING;
        end
      end
    endcase
    res.nrt = tbl_next_run[s];
    return res;
  endfunction

  // Offers one item, waits for its handshake and records the expected result.
  task automatic send_item(input op_t op, input logic [SLOT_W-1:0] slot,
                           input logic [TICK_W-1:0] d, input logic [TICK_W-1:0] now,
                           input logic typed, input sched_res_t typed_res);
    sched_res_t res;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({now, d, slot});
    do @(posedge clk); while (!in_tready);
    res = slot_table_result(op, slot, d, now);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes task_count and reads it back in a second transfer.
  task automatic set_task_count(input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_TASK_COUNT;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    slots_in_use = int'(val[COUNT_W-1:0]);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(val[COUNT_W-1:0])) begin
      errors++;
      $display("%0t: task_count read back: expected %0d, actual %0d",
               $time, val[COUNT_W-1:0], cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    sched_res_t        want;
    logic [SLOT_W-1:0] got_slot;
    logic [EV_W-1:0]   got_ev;
    logic [TICK_W-1:0] got_nrt;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_slot = out_tdata[SLOT_W-1:0];
        got_ev   = out_tdata[SLOT_W +: EV_W];
        got_nrt  = out_tdata[SLOT_W + EV_W +: TICK_W];
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected item: expected none, actual slot %0d event %0d tick %h",
                   $time, got_slot, got_ev, got_nrt);
        end else begin
          want = pending_results.pop_front();
          if (got_slot !== want.slot || got_ev !== want.ev || got_nrt !== want.nrt) begin
            errors++;
            $display("%0t: mismatch: expected slot %0d event %0d tick %h,",
                     $time, want.slot, want.ev, want.nrt);
            $display("%0t:           actual slot %0d event %0d tick %h",
                     $time, got_slot, got_ev, got_nrt);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int                i;
    int                p;
    int                n;
    int                cnt;
    int                sent;
    int                r;
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] d;
    logic [TICK_W-1:0] tick;
    int                phase_cnt [N_PHASES];

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_STEP;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = REG_TASK_COUNT;
    cfg_pwdata  = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    for (i = 0; i < SLOTS; i++) begin
      tbl_state[i]    = ST_INIT;
      tbl_reported[i] = ST_INIT;
      tbl_next_run[i] = '0;
      tbl_interval[i] = '0;
    end
    rr_slot = 0;
    slots_in_use = 0;
    tick = 32'd400;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        drain();
        set_task_count(DIR_TAB[i].d);
      end else begin
        send_item(DIR_TAB[i].op, DIR_TAB[i].slot, DIR_TAB[i].d, DIR_TAB[i].now,
                  DIR_TAB[i].typed, DIR_TAB[i].res);
      end
    end

    phase_cnt = '{16, 1, 0, 16, $urandom_range(2, 15), $urandom_range(2, 15), 5, 16};
    for (p = 0; p < N_PHASES; p++) begin
      drain();
      cnt = phase_cnt[p];
      set_task_count(cnt);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      // One long output stall while items keep coming, so the input backs up.
      if (p == 4) hold_left = 400;
      n = (cnt > SLOTS) ? SLOTS : cnt;
      sent = 0;
      // Bring most slots in use to life so that steps see real activity.
      for (i = 0; i < n; i++) begin
        if ($urandom_range(3) != 0) begin
          send_item(OP_INTERVAL, i[SLOT_W-1:0], $urandom_range(1, 15), tick, 1'b0, '0);
          send_item(OP_START, i[SLOT_W-1:0], $urandom_range(0, 10), tick, 1'b0, '0);
          sent += 2;
        end
      end
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 45)      op = OP_STEP;
        else if (r < 49) op = OP_NOP;
        else             op = op_t'($urandom_range(1, 6));
        if (n > 0 && $urandom_range(3) != 0) slot = SLOT_W'($urandom_range(n - 1));
        else                                 slot = SLOT_W'($urandom_range(SLOTS - 1));
        r = $urandom_range(99);
        if (r < 25)      d = '0;
        else if (r < 75) d = $urandom_range(1, 20);
        else             d = $urandom;
        if ($urandom_range(99) < 4) tick = $urandom;
        else                        tick = tick + $urandom_range(0, 6);
        send_item(op, slot, d, tick, 1'b0, '0);
        sent++;
      end
    end

    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/ptts_pkg.sv
design/ptts_table.sv
design/ptts_engine.sv
design/periodic_task_timer_scheduler.sv
design/ptts_checker.sv
sim/periodic_task_timer_scheduler_test.sv
